[src/mrac_pkg.sv]
`default_nettype none

package mrac_pkg;

    localparam int MAX_VARS   = 8;
    localparam int DIGIT_BITS = 4;
    localparam int CARD_BITS  = 4;
    localparam int INDEX_BITS = 32;
    localparam int COUNT_BITS = 4;
    localparam int VPOS_BITS  = 3;
    localparam int CMD_BITS   = 3;
    localparam int DATA_BITS  = 32;
    localparam int IN_BITS    = 48;
    localparam int OUT_BITS   = 80;
    // Radix-16 long division: one dividend nibble per step.
    localparam int DIV_STEPS  = INDEX_BITS / CARD_BITS;

    typedef logic [DIGIT_BITS-1:0] digit_t;
    typedef digit_t [MAX_VARS-1:0] digit_vec_t;
    typedef logic [CARD_BITS-1:0] card_t;
    typedef card_t [MAX_VARS-1:0] card_vec_t;
    typedef logic [MAX_VARS-1:0] var_mask_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_STEP_ONE    = 3'd0,
        CMD_STEP_ALL    = 3'd1,
        CMD_STEP_MASKED = 3'd2,
        CMD_LOAD        = 3'd3,
        CMD_SET_ALL     = 3'd4
    } cmd_t;

    typedef enum logic {
        REG_VAR_COUNT = 1'b0,
        REG_CARDS     = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CALC,
        ST_OUT
    } state_t;

    // A cardinality of zero behaves as one.
    function automatic card_t eff_card(input card_t c);
        eff_card = (c == '0) ? card_t'(1) : c;
    endfunction

endpackage

`default_nettype wire

[src/mrac_stepper.sv]
`default_nettype none

module mrac_stepper (
    input  mrac_pkg::digit_vec_t digits_in,
    input  mrac_pkg::card_vec_t  cards,
    input  mrac_pkg::var_mask_t  step_mask,
    input  mrac_pkg::var_mask_t  use_mask,
    input  mrac_pkg::var_mask_t  unknown_mask,
    output mrac_pkg::digit_vec_t digits_out,
    output logic                 advanced
);
    import mrac_pkg::*;

    logic                carry;
    logic [DIGIT_BITS:0] bumped;

    // Odometer carry chain: the first participating variable that does not
    // wrap absorbs the carry and ends the step.
    always_comb
    begin
        digits_out = digits_in;
        carry      = 1'b1;
        bumped     = '0;
        for (int k = 0; k < MAX_VARS; k++)
        begin
            if (carry && step_mask[k] && use_mask[k] && !unknown_mask[k])
            begin
                bumped = (DIGIT_BITS+1)'(digits_in[k]) + (DIGIT_BITS+1)'(1);
                if (bumped >= (DIGIT_BITS+1)'(eff_card(cards[k])))
                begin
                    digits_out[k] = '0;
                end
                else
                begin
                    digits_out[k] = bumped[DIGIT_BITS-1:0];
                    carry         = 1'b0;
                end
            end
        end
        advanced = !carry;
    end

endmodule

`default_nettype wire

[src/mrac_divider.sv]
`default_nettype none

module mrac_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [mrac_pkg::INDEX_BITS-1:0]    dividend,
    input  mrac_pkg::card_t                    divisor,
    output logic                               done,
    output logic [mrac_pkg::INDEX_BITS-1:0]    quotient,
    output mrac_pkg::card_t                    remainder
);
    import mrac_pkg::*;

    localparam int STEP_BITS = $clog2(DIV_STEPS);
    localparam int WIDE_BITS = 2 * CARD_BITS;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic [INDEX_BITS-1:0] num_reg, num_next;
    logic [INDEX_BITS-1:0] quo_reg, quo_next;
    card_t                 rem_reg, rem_next;
    card_t                 div_reg, div_next;

    logic [WIDE_BITS-1:0]  partial;
    logic [WIDE_BITS-1:0]  multiple;
    logic [WIDE_BITS-1:0]  taken;
    card_t                 q_digit;

    // One quotient digit per cycle: the partial remainder stays below the
    // divisor, so the digit is the largest multiple that fits.
    always_comb
    begin
        partial  = {rem_reg, num_reg[INDEX_BITS-1 -: CARD_BITS]};
        q_digit  = '0;
        taken    = '0;
        multiple = '0;
        for (int m = 1; m < (1 << CARD_BITS); m++)
        begin
            multiple = WIDE_BITS'(m) * WIDE_BITS'(div_reg);
            if (multiple <= partial)
            begin
                q_digit = CARD_BITS'(m);
                taken   = multiple;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            num_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            num_next  = num_reg << CARD_BITS;
            quo_next  = {quo_reg[INDEX_BITS-CARD_BITS-1:0], q_digit};
            rem_next  = CARD_BITS'(partial - taken);
            step_next = step_reg + STEP_BITS'(1);
            if (step_reg == STEP_BITS'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[src/mixed_radix_assignment_counter_core.sv]
`default_nettype none

// Mixed-radix assignment counter: holds up to eight variables with
// configured cardinalities and returns one result beat per command beat.
// Step and set commands update the digits in the accept cycle, then the
// flat index is rebuilt one variable in use at a time through the shared
// multiply-accumulate (stride times digit, stride times cardinality),
// and the result is then loaded into the output register. Loading an
// index first runs the radix-16 divider once per variable in use, then
// rebuilds the flat index likewise. The input is not ready while a command
// is in flight, but a finished result may wait on the output side while
// the next command is taken.
module mixed_radix_assignment_counter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [mrac_pkg::DATA_BITS-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, from bit 0: var_pos[2:0], var_mask[7:0], load_value[31:0],
    // set_value[3:0], set_unknown.
    input  logic [mrac_pkg::IN_BITS-1:0]      s_tdata,
    // s_tuser: cmd[2:0].
    input  logic [mrac_pkg::CMD_BITS-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, from bit 0: flat_index[31:0], advanced, digits[31:0],
    // unknown_mask[7:0], unknown_count[3:0], zero padding.
    output logic [mrac_pkg::OUT_BITS-1:0]     m_tdata
);
    import mrac_pkg::*;

    state_t                state_reg, state_next;
    logic [COUNT_BITS-1:0] var_count_reg, var_count_next;
    card_vec_t             cards_reg, cards_next;
    digit_vec_t            digit_reg, digit_next;
    var_mask_t             unk_reg, unk_next;
    logic [INDEX_BITS-1:0] load_reg, load_next;
    logic [COUNT_BITS-1:0] k_reg, k_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [INDEX_BITS-1:0] stride_reg, stride_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  adv_reg, adv_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   out_data_reg, out_data_next;

    cmd_t                  in_cmd;
    logic [VPOS_BITS-1:0]  in_pos;
    var_mask_t             in_mask;
    logic [INDEX_BITS-1:0] in_load;
    digit_t                in_set_value;
    logic                  in_set_unknown;

    logic [COUNT_BITS-1:0] n_vars;
    var_mask_t             use_mask;
    var_mask_t             step_mask;
    digit_vec_t            step_digits;
    logic                  step_adv;
    logic [VPOS_BITS-1:0]  kk;
    card_t                 card_k;
    logic [INDEX_BITS-1:0] term;
    digit_vec_t            shown_digits;

    logic                  div_start;
    logic                  div_done;
    logic [INDEX_BITS-1:0] div_quo;
    card_t                 div_rem;

    assign in_cmd         = cmd_t'(s_tuser);
    assign in_pos         = s_tdata[2:0];
    assign in_mask        = s_tdata[10:3];
    assign in_load        = s_tdata[42:11];
    assign in_set_value   = DIGIT_BITS'(s_tdata[46:43]);
    assign in_set_unknown = s_tdata[47];

    assign n_vars = (var_count_reg > COUNT_BITS'(MAX_VARS)) ? COUNT_BITS'(MAX_VARS)
                                                            : var_count_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_VARS; k++)
        begin
            use_mask[k]     = (COUNT_BITS'(k) < n_vars);
            shown_digits[k] = (use_mask[k] && !unk_reg[k]) ? digit_reg[k] : '0;
        end
    end

    always_comb
    begin
        case (in_cmd)
            CMD_STEP_ONE:    step_mask = var_mask_t'(1) << in_pos;
            CMD_STEP_MASKED: step_mask = in_mask;
            default:         step_mask = '1;
        endcase
    end

    mrac_stepper u_stepper (
        .digits_in    (digit_reg),
        .cards        (cards_reg),
        .step_mask    (step_mask),
        .use_mask     (use_mask),
        .unknown_mask (unk_reg),
        .digits_out   (step_digits),
        .advanced     (step_adv)
    );

    assign kk        = k_reg[VPOS_BITS-1:0];
    assign card_k    = eff_card(cards_reg[kk]);
    assign term      = stride_reg * INDEX_BITS'(digit_reg[kk]);
    assign div_start = (state_reg == ST_DIV_START);

    mrac_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (load_reg),
        .divisor   (card_k),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        var_count_next = var_count_reg;
        cards_next     = cards_reg;
        digit_next     = digit_reg;
        unk_next       = unk_reg;
        load_next      = load_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        stride_next    = stride_reg;
        cnt_next       = cnt_reg;
        adv_next       = adv_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_VAR_COUNT: var_count_next = cfg_data[COUNT_BITS-1:0];
                REG_CARDS:     cards_next     = card_vec_t'(cfg_data);
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    k_next      = '0;
                    idx_next    = '0;
                    stride_next = INDEX_BITS'(1);
                    cnt_next    = '0;
                    adv_next    = 1'b0;
                    state_next  = ST_CALC;
                    case (in_cmd) inside
                        CMD_STEP_ONE, CMD_STEP_ALL, CMD_STEP_MASKED:
                        begin
                            digit_next = step_digits;
                            adv_next   = step_adv;
                        end
                        CMD_LOAD:
                        begin
                            unk_next  = unk_reg & ~use_mask;
                            load_next = in_load;
                            if (n_vars != '0)
                            begin
                                state_next = ST_DIV_START;
                            end
                        end
                        CMD_SET_ALL:
                        begin
                            for (int k = 0; k < MAX_VARS; k++)
                            begin
                                if (use_mask[k])
                                begin
                                    digit_next[k] = in_set_unknown ? '0 : in_set_value;
                                end
                            end
                            unk_next = in_set_unknown ? (unk_reg | use_mask)
                                                      : (unk_reg & ~use_mask);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    digit_next[kk] = DIGIT_BITS'(div_rem);
                    load_next      = div_quo;
                    if (k_reg == n_vars - COUNT_BITS'(1))
                    begin
                        k_next     = '0;
                        state_next = ST_CALC;
                    end
                    else
                    begin
                        k_next     = k_reg + COUNT_BITS'(1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_CALC:
            begin
                if (k_reg < n_vars)
                begin
                    if (unk_reg[kk])
                    begin
                        cnt_next = cnt_reg + COUNT_BITS'(1);
                    end
                    else
                    begin
                        idx_next = idx_reg + term;
                    end
                    stride_next = stride_reg * INDEX_BITS'(card_k);
                    k_next      = k_reg + COUNT_BITS'(1);
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Hold the finished result until the output register frees up.
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {3'b000, cnt_reg, unk_reg & use_mask,
                                      shown_digits, adv_reg, idx_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            var_count_reg <= '0;
            cards_reg     <= '0;
            digit_reg     <= '0;
            unk_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            var_count_reg <= var_count_next;
            cards_reg     <= cards_next;
            digit_reg     <= digit_next;
            unk_reg       <= unk_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        load_reg     <= load_next;
        idx_reg      <= idx_next;
        stride_reg   <= stride_next;
        cnt_reg      <= cnt_next;
        adv_reg      <= adv_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
